/* design/bds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_pkg: shared types and constants of the 2x2 BGRA box decimator
// Widths of the pixel, pair-sum and line store, and the width clamp.
// ----------------------------------------------------------------------------
package bds_pkg;

	localparam int MAX_WIDTH   = 4096;
	localparam int HALF_DEPTH  = MAX_WIDTH / 2;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int WID_W       = $clog2(MAX_WIDTH + 1);
	localparam int IDX_W       = $clog2(HALF_DEPTH);
	localparam int CHAN_W      = 8;
	localparam int NUM_CHAN    = 4;
	localparam int SUM_W       = CHAN_W + 1;
	localparam int ENTRY_W     = SUM_W * NUM_CHAN;
	localparam int PIX_W       = CHAN_W * NUM_CHAN;
	localparam int WIDTH_RESET = 1024;
	localparam int WIDTH_MIN   = 2;

	typedef struct packed {
		logic [CHAN_W-1:0] alpha;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic             odd_col;
		logic             odd_row;
		logic             last;
		logic [IDX_W-1:0] idx;
	} pos_t;

	function automatic logic [WID_W-1:0] clamp_width(input logic [WID_W-1:0] v);
		logic [WID_W-1:0] w;
		w = v;
		if (w < WID_W'(WIDTH_MIN)) begin
			w = WID_W'(WIDTH_MIN);
		end else if (w > WID_W'(MAX_WIDTH)) begin
			w = WID_W'(MAX_WIDTH);
		end
		return {w[WID_W-1:1], 1'b0};
	endfunction

endpackage

/* design/bds_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bds_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* design/bds_pos.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_pos: column and row-parity tracking
// Resolves the position of the incoming item and advances it on accept.
// ----------------------------------------------------------------------------
module bds_pos import bds_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             start_of_frame,
	input  logic [WID_W-1:0] width,
	output pos_t             pos
);

	logic [COL_W-1:0] col_q;
	logic             odd_q;
	logic [COL_W-1:0] col_a;
	logic             odd_a;
	logic [COL_W-1:0] col_c;
	logic             odd_c;
	logic [WID_W-1:0] col_inc;
	logic [COL_W-1:0] col_next;
	logic             odd_next;

	always_comb begin
		col_a = start_of_frame ? '0 : col_q;
		odd_a = start_of_frame ? 1'b0 : odd_q;
		if ({1'b0, col_a} >= width) begin
			col_c = '0;
			odd_c = ~odd_a;
		end else begin
			col_c = col_a;
			odd_c = odd_a;
		end
		col_inc = {1'b0, col_c} + WID_W'(1);
		if (col_inc >= width) begin
			col_next = '0;
			odd_next = ~odd_c;
		end else begin
			col_next = col_inc[COL_W-1:0];
			odd_next = odd_c;
		end
		pos.odd_col = col_c[0];
		pos.odd_row = odd_c;
		pos.last    = (col_inc == width);
		pos.idx     = col_c[COL_W-1:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			odd_q <= 1'b0;
		end else if (accept) begin
			col_q <= col_next;
			odd_q <= odd_next;
		end
	end

endmodule

/* design/bds_avg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_avg: pair sums, line store and four-pixel average
// Even rows fill the line store; odd rows combine it into the result register.
// ----------------------------------------------------------------------------
module bds_avg import bds_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   accept,
	input  pixel_t pix,
	input  pos_t   pos,
	output logic   in_ready,
	output logic   out_valid,
	input  logic   out_ready,
	output pixel_t out_pix,
	output logic   out_last
);

	pixel_t               held_q;
	logic [ENTRY_W-1:0]   pair_sum;
	logic                 wr_en;
	logic                 rd_en;
	logic [ENTRY_W-1:0]   rd_data;
	logic                 valid_s1;
	logic [ENTRY_W-1:0]   sum_s1;
	logic                 last_s1;
	logic                 out_valid_q;
	pixel_t               out_pix_q;
	logic                 out_last_q;
	logic                 advance;
	pixel_t               avg;

	assign pair_sum = {
		{1'b0, held_q.alpha} + {1'b0, pix.alpha},
		{1'b0, held_q.red}   + {1'b0, pix.red},
		{1'b0, held_q.green} + {1'b0, pix.green},
		{1'b0, held_q.blue}  + {1'b0, pix.blue}
	};

	assign wr_en = accept && pos.odd_col && !pos.odd_row;
	assign rd_en = accept && pos.odd_col && pos.odd_row;

	bds_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(HALF_DEPTH)
	) u_line (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (pos.idx),
		.wr_data (pair_sum),
		.rd_en   (rd_en),
		.rd_addr (pos.idx),
		.rd_data (rd_data)
	);

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		logic [SUM_W:0] s [NUM_CHAN];
		logic [PIX_W-1:0] packed_avg;
		for (int k = 0; k < NUM_CHAN; k++) begin
			s[k] = {1'b0, rd_data[k*SUM_W +: SUM_W]} + {1'b0, sum_s1[k*SUM_W +: SUM_W]};
			packed_avg[k*CHAN_W +: CHAN_W] = s[k][SUM_W:2];
		end
		avg = pixel_t'(packed_avg);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && !pos.odd_col) begin
				held_q <= pix;
			end
			if (in_ready) begin
				valid_s1 <= rd_en;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			sum_s1  <= pair_sum;
			last_s1 <= pos.last;
		end
		if (advance && valid_s1) begin
			out_pix_q  <= avg;
			out_last_q <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pix   = out_pix_q;
	assign out_last  = out_last_q;

endmodule

/* design/box_downsample_2x2_bgra8.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_downsample_2x2_bgra8: 2x2 box-filter decimator for BGRA8 pixels
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   s_      | in        | s_tvalid/s_tready  | s_tdata BGRA, s_tuser SOF
//   m_      | out       | m_tvalid/m_tready  | m_tdata BGRA average, m_tlast
//   cfg_    | in        | cfg_wr_en          | cfg_wr_data source width
//
// One pixel per cycle in unless a stalled output backs up the pipeline; the result
// for the second pixel of an odd-row pair passes the line store read, then the add.
// The line store (2048 x 36) is one write and one read port per cycle.
// Reset clears position, parity and pipeline valids; the store is not cleared.
// A stalled output holds the result stage and, behind it, one pending item.
// ----------------------------------------------------------------------------
module box_downsample_2x2_bgra8 import bds_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,   // blue_in, green_in, red_in, alpha_in
	input  logic             s_tuser,   // start_of_frame
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [31:0]      m_tdata,   // blue_out, green_out, red_out, alpha_out
	output logic             m_tlast,
	input  logic             cfg_wr_en,
	input  logic [WID_W-1:0] cfg_wr_data
);

	logic [WID_W-1:0] width_q;
	logic             accept;
	pos_t             pos;
	pixel_t           out_pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WID_W'(WIDTH_RESET);
		end else if (cfg_wr_en) begin
			width_q <= clamp_width(cfg_wr_data);
		end
	end

	assign accept = s_tvalid && s_tready;

	bds_pos u_pos (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.start_of_frame (s_tuser),
		.width          (width_q),
		.pos            (pos)
	);

	bds_avg u_avg (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.pix       (pixel_t'(s_tdata)),
		.pos       (pos),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pix   (out_pix),
		.out_last  (m_tlast)
	);

	assign m_tdata = PIX_W'(out_pix);

endmodule

/* design/bds_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_check: port-level checks of the box decimator
// Output handshake rules, result origin and input backpressure.
// ----------------------------------------------------------------------------
module bds_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output item dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("output item without an accepted input item");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output drains");

endmodule

bind box_downsample_2x2_bgra8 bds_check u_bds_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

/* tb/tb_box_downsample_2x2_bgra8.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_downsample_2x2_bgra8: self-checking bench for the 2x2 BGRA decimator
// Streams BGRA pixels through the block in frames of several widths, predicts
// each averaged output pixel with a line-store model of its own and checks
// every output item, field by field, against the oldest pending prediction.
// Both stream sides idle at random; one long frame runs without gaps.
// ----------------------------------------------------------------------------
module tb_box_downsample_2x2_bgra8 import bds_pkg::*; ();

	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_PIXELS = 1100;
	localparam int NOGAP_WIDTH  = 128;
	localparam int NOGAP_ROWS   = 4;

	typedef struct {
		logic   sof;
		pixel_t px;
	} src_pixel_t;

	typedef struct {
		pixel_t px;
		logic   last;
	} avg_pixel_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [31:0]      s_tdata = '0;    // blue_in, green_in, red_in, alpha_in
	logic             s_tuser = 1'b0;  // start_of_frame
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [31:0]      m_tdata;         // blue_out, green_out, red_out, alpha_out
	logic             m_tlast;
	logic             cfg_wr_en = 1'b0;
	logic [WID_W-1:0] cfg_wr_data = '0;

	src_pixel_t pending_pixels[$];
	avg_pixel_t expected_avgs[$];
	src_pixel_t next_pix;
	avg_pixel_t want_avg;
	pixel_t     seen_avg;

	logic [ENTRY_W-1:0] line_sums [HALF_DEPTH];
	pixel_t             pair_first;
	int                 col_pos;
	logic               row_odd;
	logic [WID_W-1:0]   width_reg;

	logic no_gaps = 1'b0;
	int   mismatches = 0;
	int   avgs_seen = 0;
	int   quiet_cycles = 0;
	int   pixels_queued = 0;

	box_downsample_2x2_bgra8 DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #10 clk = ~clk;

	function automatic int active_width();
		int w;
		w = int'(width_reg);
		if (w < 2) w = 2;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		return w & ~1;
	endfunction

	task automatic advance_decimator(input logic sof, input pixel_t px);
		int               w;
		int               idx;
		logic [SUM_W-1:0] pair;
		logic [SUM_W+1:0] total;
		logic [ENTRY_W-1:0] entry;
		avg_pixel_t       avg;
		w = active_width();
		if (sof) begin
			col_pos = 0;
			row_odd = 1'b0;
		end
		if (col_pos >= w) begin
			col_pos = 0;
			row_odd = ~row_odd;
		end
		if (col_pos % 2 == 0) begin
			pair_first = px;
		end else begin
			idx = col_pos / 2;
			entry = '0;
			for (int k = 0; k < NUM_CHAN; k++) begin
				pair = {1'b0, pair_first[k*CHAN_W +: CHAN_W]} + {1'b0, px[k*CHAN_W +: CHAN_W]};
				entry[k*SUM_W +: SUM_W] = pair;
				total = {2'b00, line_sums[idx][k*SUM_W +: SUM_W]} + {2'b00, pair};
				avg.px[k*CHAN_W +: CHAN_W] = total[SUM_W:2];
			end
			if (!row_odd) begin
				line_sums[idx] = entry;
			end else begin
				avg.last = (col_pos + 1 == w);
				expected_avgs.push_back(avg);
			end
		end
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_odd = ~row_odd;
		end
	endtask

	task automatic report_mismatch(input string what);
		if (mismatches < 40) $display("MISMATCH @%0t: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic queue_pixel(input logic sof, input logic [31:0] data);
		src_pixel_t p;
		p.sof = sof;
		p.px = data;
		pending_pixels.push_back(p);
		pixels_queued++;
	endtask

	task automatic queue_run(input logic sof_first, input int count, input logic stray_sof);
		logic sof;
		for (int i = 0; i < count; i++) begin
			sof = (i == 0) ? sof_first : (stray_sof && $urandom_range(199) == 0);
			queue_pixel(sof, $urandom);
		end
	endtask

	task automatic settle();
		do @(negedge clk);
		while (pending_pixels.size() != 0 || s_tvalid || expected_avgs.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_width(input logic [WID_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		width_reg = value;
	endtask

	task automatic random_phase();
		int               pick;
		logic [WID_W-1:0] wv;
		int               w;
		int               rows;
		pick = $urandom_range(99);
		if (pick < 5) begin
			wv = WID_W'($urandom_range(3));
		end else if (pick < 9) begin
			wv = WID_W'($urandom_range(MAX_WIDTH - 64, (1 << WID_W) - 1));
		end else begin
			wv = WID_W'($urandom_range(4, 64));
		end
		write_width(wv);
		w = active_width();
		if (w > 64) begin
			queue_run(1'b1, $urandom_range(1, 48), 1'b0);
		end else begin
			repeat ($urandom_range(1, 3)) begin
				rows = $urandom_range(2, 6);
				queue_run(1'b1, rows * w, 1'b1);
				if ($urandom_range(9) == 0) queue_run(1'b0, $urandom_range(1, 2 * w), 1'b1);
			end
		end
		settle();
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) advance_decimator(s_tuser, pixel_t'(s_tdata));
			if (!s_tvalid || s_tready) begin
				if (pending_pixels.size() != 0 && (no_gaps || $urandom_range(99) >= 25)) begin
					next_pix = pending_pixels.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_pix.px;
					s_tuser <= next_pix.sof;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen_avg = m_tdata;
				if (expected_avgs.size() == 0) begin
					report_mismatch($sformatf("item %0d with no average pending", avgs_seen));
				end else begin
					want_avg = expected_avgs.pop_front();
					if (seen_avg.blue !== want_avg.px.blue)
						report_mismatch($sformatf("item %0d blue %0d, want %0d",
							avgs_seen, seen_avg.blue, want_avg.px.blue));
					if (seen_avg.green !== want_avg.px.green)
						report_mismatch($sformatf("item %0d green %0d, want %0d",
							avgs_seen, seen_avg.green, want_avg.px.green));
					if (seen_avg.red !== want_avg.px.red)
						report_mismatch($sformatf("item %0d red %0d, want %0d",
							avgs_seen, seen_avg.red, want_avg.px.red));
					if (seen_avg.alpha !== want_avg.px.alpha)
						report_mismatch($sformatf("item %0d alpha %0d, want %0d",
							avgs_seen, seen_avg.alpha, want_avg.px.alpha));
					if (m_tlast !== want_avg.last)
						report_mismatch($sformatf("item %0d last %b, want %b",
							avgs_seen, m_tlast, want_avg.last));
				end
				avgs_seen++;
			end
			m_tready <= no_gaps || $urandom_range(99) >= 25;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("box_downsample_2x2_bgra8 verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		width_reg = WID_W'(WIDTH_RESET);
		col_pos = 0;
		row_odd = 1'b0;
		pair_first = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// partial even row at the reset width
		queue_pixel(1'b1, 32'hFFFF_FFFF);
		queue_pixel(1'b0, 32'hFFFF_FFFF);
		queue_pixel(1'b0, 32'h0000_0000);
		queue_pixel(1'b0, 32'h0000_0000);
		queue_pixel(1'b0, 32'h0302_0100);
		queue_pixel(1'b0, 32'h0001_0203);
		queue_pixel(1'b0, 32'h8080_8080);
		queue_pixel(1'b0, 32'h7F7F_7F7F);
		settle();

		// shrink the width mid-row: the row ends and an odd row follows
		write_width(WID_W'(4));
		queue_pixel(1'b0, 32'hFFFF_FFFF);
		queue_pixel(1'b0, 32'hFFFF_FFFF);
		queue_pixel(1'b0, 32'h0000_0000);
		queue_pixel(1'b0, 32'h0101_0101);
		settle();

		// width below the minimum, rounding down of the sum
		write_width(WID_W'(0));
		queue_pixel(1'b1, 32'h0000_0001);
		queue_pixel(1'b0, 32'h0000_0000);
		queue_pixel(1'b0, 32'h0101_0101);
		queue_pixel(1'b0, 32'h0202_0202);
		settle();

		// long frame, no idling on either side
		write_width(WID_W'(NOGAP_WIDTH));
		no_gaps = 1'b1;
		queue_run(1'b1, NOGAP_ROWS * NOGAP_WIDTH, 1'b0);
		settle();
		no_gaps = 1'b0;

		pixels_queued = 0;
		while (pixels_queued < RANDOM_PIXELS) random_phase();

		settle();
		if (mismatches == 0) begin
			$display("box_downsample_2x2_bgra8 verification clean");
		end else begin
			$display("box_downsample_2x2_bgra8 verification failed");
		end
		$finish;
	end

endmodule

/* files.f */
design/bds_pkg.sv
design/bds_ram.sv
design/bds_pos.sv
design/bds_avg.sv
design/box_downsample_2x2_bgra8.sv
design/bds_check.sv
tb/tb_box_downsample_2x2_bgra8.sv
